// ----- hdl/csq_pkg.sv -----
// ----------------------------------------------------------------------------
// csq_pkg
// Shared constants and types of the chi-square statistic block.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_WIDTH_DEF = 48;

    // result and scale factor widths are fixed by the interface
    localparam int OUT_WIDTH  = 48;
    localparam int DRAW_WIDTH = 24;
    localparam int HALF_WIDTH = OUT_WIDTH / 2;

    localparam logic [DRAW_WIDTH-1:0] DRAW_RESET = DRAW_WIDTH'(1);

    // per-bin control that travels with the data down the divider chain
    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } csq_ctrl_t;

    // end-of-histogram job handed from the accumulator to the scaler
    typedef struct packed {
        logic valid;
        logic zero;
        logic ovf;
    } csq_job_t;

endpackage

// ----- hdl/csq_square.sv -----
// ----------------------------------------------------------------------------
// csq_square
// Front stage: absolute difference of the two fractions, squared.
// ----------------------------------------------------------------------------
module csq_square #(
    parameter int FRAC_BITS = csq_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [FRAC_BITS:0]            in_obs,
    input  logic [FRAC_BITS:0]            in_exp,
    input  logic                          in_last,
    output csq_pkg::csq_ctrl_t            out_ctrl,
    output logic [2*(FRAC_BITS+1)-1:0]    out_sq,
    output logic [FRAC_BITS:0]            out_div
);
    import csq_pkg::*;

    localparam int IW = FRAC_BITS + 1;
    localparam int TW = 2 * IW;

    logic [IW-1:0] diff;
    logic [TW-1:0] sq_next;
    logic [TW-1:0] sq_reg;
    logic [IW-1:0] div_reg;
    csq_ctrl_t     ctrl_reg;

    always_comb begin
        diff    = (in_obs >= in_exp) ? (in_obs - in_exp) : (in_exp - in_obs);
        sq_next = TW'(diff) * TW'(diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg.valid <= in_valid;
            ctrl_reg.last  <= in_last;
            ctrl_reg.zero  <= (in_exp == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= sq_next;
            div_reg <= in_exp;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_sq   = sq_reg;
    assign out_div  = div_reg;

endmodule

// ----- hdl/csq_div_cell.sv -----
// ----------------------------------------------------------------------------
// csq_div_cell
// One restoring-division cell: settles one quotient bit per cell.
// ----------------------------------------------------------------------------
module csq_div_cell #(
    parameter int FRAC_BITS = csq_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  csq_pkg::csq_ctrl_t            in_ctrl,
    input  logic [FRAC_BITS:0]            in_rem,
    input  logic [2*(FRAC_BITS+1)-1:0]    in_dq,
    input  logic [FRAC_BITS:0]            in_div,
    output csq_pkg::csq_ctrl_t            out_ctrl,
    output logic [FRAC_BITS:0]            out_rem,
    output logic [2*(FRAC_BITS+1)-1:0]    out_dq,
    output logic [FRAC_BITS:0]            out_div
);
    import csq_pkg::*;

    localparam int IW = FRAC_BITS + 1;
    localparam int TW = 2 * IW;

    logic [IW:0]   trial;
    logic [IW:0]   sub;
    logic          qbit;
    logic [IW-1:0] rem_next;
    logic [TW-1:0] dq_next;

    logic [IW-1:0] rem_reg;
    logic [TW-1:0] dq_reg;
    logic [IW-1:0] div_reg;
    csq_ctrl_t     ctrl_reg;

    // shift in the next dividend bit, subtract if it fits, shift the quotient bit in
    always_comb begin
        trial    = {in_rem, in_dq[TW-1]};
        sub      = trial - (IW+1)'(in_div);
        qbit     = (trial >= (IW+1)'(in_div));
        rem_next = qbit ? sub[IW-1:0] : trial[IW-1:0];
        dq_next  = {in_dq[TW-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            div_reg <= in_div;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_rem  = rem_reg;
    assign out_dq   = dq_reg;
    assign out_div  = div_reg;

endmodule

// ----- hdl/csq_accum.sv -----
// ----------------------------------------------------------------------------
// csq_accum
// Saturating running sum of the bin terms and the histogram flags.
// ----------------------------------------------------------------------------
module csq_accum #(
    parameter int FRAC_BITS = csq_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = csq_pkg::SUM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  csq_pkg::csq_ctrl_t            in_ctrl,
    input  logic [2*(FRAC_BITS+1)-1:0]    in_term,
    output csq_pkg::csq_job_t             job,
    output logic [SUM_WIDTH-1:0]          job_sum
);
    import csq_pkg::*;

    localparam int TW = 2 * (FRAC_BITS + 1);
    localparam int AW = ((TW > SUM_WIDTH) ? TW : SUM_WIDTH) + 1;

    logic [SUM_WIDTH-1:0] sum_reg, sum_next, sum_acc;
    logic                 zero_reg, zero_next, zero_acc;
    logic                 ovf_reg, ovf_next, ovf_acc;
    logic [AW-1:0]        term_x;
    logic [AW-1:0]        room_x;
    logic [AW-1:0]        sum_add;

    always_comb begin
        term_x   = AW'(in_term);
        room_x   = AW'(~sum_reg);
        sum_add  = term_x + AW'(sum_reg);
        sum_acc  = sum_reg;
        zero_acc = zero_reg;
        ovf_acc  = ovf_reg;
        if (in_ctrl.zero) begin
            zero_acc = 1'b1;
        end else if (term_x > room_x) begin
            sum_acc = '1;
            ovf_acc = 1'b1;
        end else begin
            sum_acc = sum_add[SUM_WIDTH-1:0];
        end

        sum_next  = sum_reg;
        zero_next = zero_reg;
        ovf_next  = ovf_reg;
        job       = '0;
        if (en && in_ctrl.valid) begin
            job.valid = in_ctrl.last;
            job.zero  = zero_acc;
            job.ovf   = ovf_acc;
            // clear for the next histogram once the last bin is in
            if (in_ctrl.last) begin
                sum_next  = '0;
                zero_next = 1'b0;
                ovf_next  = 1'b0;
            end else begin
                sum_next  = sum_acc;
                zero_next = zero_acc;
                ovf_next  = ovf_acc;
            end
        end
        job_sum = sum_acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            zero_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            zero_reg <= zero_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// ----- hdl/csq_scale.sv -----
// ----------------------------------------------------------------------------
// csq_scale
// Scales the finished sum by the draw count over two multiplier passes.
// ----------------------------------------------------------------------------
module csq_scale #(
    parameter int SUM_WIDTH = csq_pkg::SUM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csq_pkg::csq_job_t                 job,
    input  logic [SUM_WIDTH-1:0]              job_sum,
    input  logic [csq_pkg::DRAW_WIDTH-1:0]    draw_count,
    output logic                              busy,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [csq_pkg::OUT_WIDTH-1:0]     m_chi_square,
    output logic                              m_expected_zero,
    output logic                              m_saturated
);
    import csq_pkg::*;

    localparam int XW  = (SUM_WIDTH > OUT_WIDTH) ? SUM_WIDTH : OUT_WIDTH;
    localparam int PW  = HALF_WIDTH + DRAW_WIDTH;
    localparam int TOT = PW + HALF_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_SUM
    } state_t;

    state_t                state_reg, state_next;
    logic [SUM_WIDTH-1:0]  sum_reg, sum_next;
    logic                  zero_reg, zero_next;
    logic                  ovf_reg, ovf_next;
    logic [PW-1:0]         plo_reg, plo_next;
    logic [PW-1:0]         phi_reg, phi_next;
    logic                  valid_reg, valid_next;
    logic [OUT_WIDTH-1:0]  chi_reg, chi_next;
    logic                  ez_reg, ez_next;
    logic                  sat_reg, sat_next;

    logic [XW-1:0]         sum_x;
    logic [TOT-1:0]        total;
    logic                  big;
    logic                  sat_prod;
    logic                  out_free;
    logic [HALF_WIDTH-1:0] mul_a;
    logic [PW-1:0]         mul_p;

    always_comb begin
        sum_x    = XW'(sum_reg);
        big      = ((sum_x >> OUT_WIDTH) != '0) && (draw_count != '0);
        total    = (TOT'(phi_reg) << HALF_WIDTH) + TOT'(plo_reg);
        sat_prod = big || ((total >> OUT_WIDTH) != '0);
        out_free = !valid_reg || m_ready;
        // one shared multiplier, low half of the sum first
        mul_a    = (state_reg == ST_LO) ? sum_x[HALF_WIDTH-1:0]
                                        : sum_x[OUT_WIDTH-1:HALF_WIDTH];
        mul_p    = PW'(mul_a) * PW'(draw_count);

        state_next = state_reg;
        sum_next   = sum_reg;
        zero_next  = zero_reg;
        ovf_next   = ovf_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        valid_next = valid_reg && !m_ready;
        chi_next   = chi_reg;
        ez_next    = ez_reg;
        sat_next   = sat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (job.valid) begin
                    sum_next   = job_sum;
                    zero_next  = job.zero;
                    ovf_next   = job.ovf;
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                plo_next   = mul_p;
                state_next = ST_HI;
            end
            ST_HI: begin
                phi_next   = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // hold until the output register is free
                if (out_free) begin
                    valid_next = 1'b1;
                    chi_next   = sat_prod ? '1 : total[OUT_WIDTH-1:0];
                    ez_next    = zero_reg;
                    sat_next   = ovf_reg || sat_prod;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        sum_reg  <= sum_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        chi_reg  <= chi_next;
        ez_reg   <= ez_next;
        sat_reg  <= sat_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign m_valid         = valid_reg;
    assign m_chi_square    = chi_reg;
    assign m_expected_zero = ez_reg;
    assign m_saturated     = sat_reg;

endmodule

// ----- hdl/chi_square_statistic.sv -----
// ----------------------------------------------------------------------------
// chi_square_statistic
// Pearson chi-square statistic over a stream of histogram bins.
// ----------------------------------------------------------------------------
// channel  direction  signals                                    transfer when
// s_       in         observed_frac, expected_frac, last_bin     s_valid & s_ready
// m_       out        chi_square, expected_zero, saturated       m_valid & m_ready
// cfg_     in         data (draw count)                          cfg_valid & cfg_ready
//
// One bin is taken per cycle unless the chain is stalled. A bin passes a squaring
// stage and a chain of 2*(FRAC_BITS+1) division cells, one quotient bit per cell,
// then the accumulator. A last bin at the end of the chain stalls it while the
// scaler (one shared 24x24 multiplier, states LO, HI and SUM) is still busy with
// the previous histogram; the scaler stays busy while its product waits for the
// output register to free up. Reset is synchronous; it clears the sum and the
// flags and sets the draw count to one.
// ----------------------------------------------------------------------------
module chi_square_statistic #(
    parameter int FRAC_BITS = csq_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = csq_pkg::SUM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [FRAC_BITS:0]                s_observed_frac,
    input  logic [FRAC_BITS:0]                s_expected_frac,
    input  logic                              s_last_bin,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [csq_pkg::OUT_WIDTH-1:0]     m_chi_square,
    output logic                              m_expected_zero,
    output logic                              m_saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csq_pkg::DRAW_WIDTH-1:0]    cfg_data
);
    import csq_pkg::*;

    localparam int IW = FRAC_BITS + 1;
    localparam int TW = 2 * IW;

    csq_ctrl_t             ctrl_w [0:TW];
    logic [IW-1:0]         rem_w  [0:TW];
    logic [TW-1:0]         dq_w   [0:TW];
    logic [IW-1:0]         div_w  [0:TW];

    logic [DRAW_WIDTH-1:0] draw_count_reg;
    logic                  advance;
    logic                  scale_busy;
    csq_job_t              job;
    logic [SUM_WIDTH-1:0]  job_sum;

    // stall the whole chain only when a last bin meets a busy scaler
    assign advance   = !(ctrl_w[TW].valid && ctrl_w[TW].last && scale_busy);
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;
    assign rem_w[0]  = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_count_reg <= DRAW_RESET;
        end else if (cfg_valid) begin
            draw_count_reg <= cfg_data;
        end
    end

    csq_square #(
        .FRAC_BITS (FRAC_BITS)
    ) u_square (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_valid (s_valid),
        .in_obs   (s_observed_frac),
        .in_exp   (s_expected_frac),
        .in_last  (s_last_bin),
        .out_ctrl (ctrl_w[0]),
        .out_sq   (dq_w[0]),
        .out_div  (div_w[0])
    );

    for (genvar i = 0; i < TW; i++) begin : g_cell
        csq_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .in_ctrl  (ctrl_w[i]),
            .in_rem   (rem_w[i]),
            .in_dq    (dq_w[i]),
            .in_div   (div_w[i]),
            .out_ctrl (ctrl_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_dq   (dq_w[i+1]),
            .out_div  (div_w[i+1])
        );
    end

    csq_accum #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .in_ctrl (ctrl_w[TW]),
        .in_term (dq_w[TW]),
        .job     (job),
        .job_sum (job_sum)
    );

    csq_scale #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_scale (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job             (job),
        .job_sum         (job_sum),
        .draw_count      (draw_count_reg),
        .busy            (scale_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chi_square    (m_chi_square),
        .m_expected_zero (m_expected_zero),
        .m_saturated     (m_saturated)
    );

endmodule

// ----- hdl/csq_checker.sv -----
// ----------------------------------------------------------------------------
// csq_checker
// Port-level checks of the chi-square statistic block.
// ----------------------------------------------------------------------------
module csq_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_last_bin,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [csq_pkg::OUT_WIDTH-1:0]     m_chi_square,
    input  logic                              m_expected_zero,
    input  logic                              m_saturated
);
    import csq_pkg::*;

    logic [7:0] open_reg;
    logic       last_xfer;
    logic       out_xfer;

    assign last_xfer = s_valid && s_ready && s_last_bin;
    assign out_xfer  = m_valid && m_ready;

    // count histograms closed on the input and not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            case ({last_xfer, out_xfer})
                2'b10:   open_reg <= open_reg + 8'd1;
                2'b01:   open_reg <= open_reg - 8'd1;
                default: open_reg <= open_reg;
            endcase
        end
    end

    // no result may be pending right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chi_square)
            && $stable(m_expected_zero) && $stable(m_saturated))
        else $error("stalled result changed");

    // every result answers a closed histogram that has no result yet
    a_result_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (open_reg != '0))
        else $error("result without an open histogram");

endmodule

bind chi_square_statistic csq_checker u_csq_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_last_bin      (s_last_bin),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_chi_square    (m_chi_square),
    .m_expected_zero (m_expected_zero),
    .m_saturated     (m_saturated)
);
